### hw/rtl/prfx_pkg.sv
// Package for the prefixed instruction encoder.
// Holds sizing constants, action codes, function codes, fixed byte values and the control struct.
// No dependencies.
`default_nettype none

package prfx_pkg;

    localparam int DATA_BITS = 32;
    localparam int MAX_TRY   = 8;

    localparam logic [1:0] ACT_PRIMARY   = 2'd0;
    localparam logic [1:0] ACT_SECONDARY = 2'd1;
    localparam logic [1:0] ACT_EXTENDED  = 2'd2;

    localparam logic [3:0] FC_JUMP  = 4'd0;
    localparam logic [3:0] FC_CJUMP = 4'd9;
    localparam logic [3:0] FC_CALL  = 4'd10;
    localparam logic [3:0] FC_PFIX  = 4'd2;
    localparam logic [3:0] FC_NFIX  = 4'd6;
    localparam logic [3:0] FC_OPR   = 4'd15;
    localparam logic [3:0] FC_LDC4  = 4'd4;

    localparam logic [7:0] PAD_BYTE  = 8'h20;
    localparam logic [7:0] EXT_BYTE1 = 8'h2A;
    localparam logic [7:0] EXT_BYTE2 = 8'hFB;

    // What the formatter needs to know about the instruction being emitted.
    typedef struct packed {
        logic [1:0] action;
        logic [3:0] fc;
        logic [7:0] idx;
        logic [3:0] total;    // bytes to emit, 1..8
        logic [3:0] enc_len;  // natural encoding length, padding excluded
    } t_emit_ctl;

endpackage

`default_nettype wire

### hw/rtl/prfx_in_if.sv
// Input channel of the prefixed instruction encoder: one instruction per transfer.
// No dependencies; plain valid/ready handshake.
`default_nettype none

interface prfx_in_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  action;
    logic        [3:0]  function_code;
    logic signed [31:0] operand;
    logic        [30:0] position;
    logic        [7:0]  op_index;

    modport source (output valid, action, function_code, operand, position, op_index,
                    input ready);
    modport sink   (input valid, action, function_code, operand, position, op_index,
                    output ready);
endinterface

`default_nettype wire

### hw/rtl/prfx_out_if.sv
// Output channel of the prefixed instruction encoder: one code byte per transfer.
// Plain valid/ready handshake, no dependencies.
`default_nettype none

interface prfx_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       last;

    modport source (output valid, code_byte, last, input ready);
    modport sink   (input valid, code_byte, last, output ready);
endinterface

`default_nettype wire

### hw/rtl/prefix_instruction_encoder_top.sv
// Prefixed instruction encoder, top level: sequencer, shared length unit, byte formatter, output register.
// Depends on prfx_pkg, prfx_in_if, prfx_out_if, prfx_len_unit and prfx_fmt.
//
// Usage:
//   i_in  carries one instruction per transfer (action, function code, operand,
//         position, operation index). o_out carries one code byte per transfer,
//         with last set on the final byte of the instruction.
//   Primary actions load the operand through negative/positive prefix bytes and
//   end with function_code<<4 | low nibble. Relative codes (0, 9, 10) encode the
//   offset from the address just past the instruction; the sequencer tries
//   lengths 1..8, one per cycle on the shared subtract/length unit, and pads
//   with 0x20 bytes when no length fits exactly. Action 3 emits nothing.
// Timing:
//   Input transfer, then for relative codes a search over lengths 1..8, then one
//   byte per cycle into the output register (1 to 8 bytes) while o_out.ready
//   allows it. i_in.ready is high only while the sequencer idles; the next
//   instruction is taken while the final byte still sits in the output register.
// Reset: i_rst_n, synchronous, clears the sequencer and the output valid.
// Stall: when o_out.ready is low the output register holds and emission waits.
`default_nettype none

module prefix_instruction_encoder_top
    import prfx_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    prfx_in_if.sink     i_in,
    prfx_out_if.source  o_out
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;

    logic [1:0]           r_state, n_state;
    logic [WORD_BITS-1:0] r_base,  n_base;
    logic [WORD_BITS-1:0] r_value, n_value;
    t_emit_ctl            r_ctl,   n_ctl;
    logic [3:0]           r_try,   n_try;
    logic                 r_fb,    n_fb;
    logic [2:0]           r_k,     n_k;
    logic                 r_out_valid, n_out_valid;
    logic [7:0]           r_out_byte,  n_out_byte;
    logic                 r_out_last,  n_out_last;

    logic [WORD_BITS-1:0] w_a, w_b, w_diff;
    logic [3:0]           w_len;
    logic [7:0]           w_byte;
    logic                 w_accept;
    logic                 w_relative;
    logic                 w_load;
    logic                 w_emit_last;
    logic                 w_has_pre;

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_relative = (i_in.function_code == FC_JUMP) || (i_in.function_code == FC_CJUMP)
                     || (i_in.function_code == FC_CALL);
    assign w_has_pre  = (i_in.op_index[7:4] != 4'd0);

    // Shared unit: operand - position (0 if not relative) on transfer, base - length in search.
    always_comb begin
        if (r_state == ST_IDLE) begin
            w_a = WORD_BITS'(i_in.operand);
            w_b = w_relative ? WORD_BITS'(i_in.position) : '0;
        end else begin
            w_a = r_base;
            w_b = WORD_BITS'(r_try);
        end
    end

    prfx_len_unit #(.WORD_BITS(WORD_BITS)) u_len (
        .i_a    (w_a),
        .i_b    (w_b),
        .o_diff (w_diff),
        .o_len  (w_len)
    );

    prfx_fmt #(.WORD_BITS(WORD_BITS)) u_fmt (
        .i_ctl   (r_ctl),
        .i_value (r_value),
        .i_k     (r_k),
        .o_byte  (w_byte)
    );

    assign w_load      = (r_state == ST_EMIT) && (!r_out_valid || o_out.ready);
    assign w_emit_last = (r_k == 3'(r_ctl.total - 4'd1));

    always_comb begin
        n_state     = r_state;
        n_base      = r_base;
        n_value     = r_value;
        n_ctl       = r_ctl;
        n_try       = r_try;
        n_fb        = r_fb;
        n_k         = r_k;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_ctl.action  = i_in.action;
                    n_ctl.fc      = i_in.function_code;
                    n_ctl.idx     = i_in.op_index;
                    n_k           = 3'd0;
                    case (i_in.action)
                        ACT_PRIMARY: begin
                            if (w_relative) begin
                                n_base  = w_diff;
                                n_try   = 4'd1;
                                n_fb    = 1'b0;
                                n_state = ST_SEARCH;
                            end else begin
                                n_value       = w_diff;
                                n_ctl.total   = w_len;
                                n_ctl.enc_len = w_len;
                                n_state       = ST_EMIT;
                            end
                        end
                        ACT_SECONDARY: begin
                            n_ctl.total   = w_has_pre ? 4'd2 : 4'd1;
                            n_ctl.enc_len = n_ctl.total;
                            n_state       = ST_EMIT;
                        end
                        ACT_EXTENDED: begin
                            n_ctl.total   = w_has_pre ? 4'd4 : 4'd3;
                            n_ctl.enc_len = n_ctl.total;
                            n_state       = ST_EMIT;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SEARCH: begin
                if (w_len == r_try) begin
                    // Exact fit wins over any earlier padded candidate.
                    n_value       = w_diff;
                    n_ctl.total   = r_try;
                    n_ctl.enc_len = w_len;
                    n_state       = ST_EMIT;
                end else begin
                    if (!r_fb && w_len < r_try) begin
                        n_value       = w_diff;
                        n_ctl.total   = r_try;
                        n_ctl.enc_len = w_len;
                        n_fb          = 1'b1;
                    end
                    if (r_try == 4'(MAX_TRY)) begin
                        n_state = n_fb ? ST_EMIT : ST_IDLE;
                    end else begin
                        n_try = r_try + 4'd1;
                    end
                end
            end
            ST_EMIT: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = w_byte;
                    n_out_last  = w_emit_last;
                    n_k         = r_k + 3'd1;
                    if (w_emit_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_fb        <= 1'b0;
            r_try       <= 4'd1;
            r_k         <= 3'd0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_fb        <= n_fb;
            r_try       <= n_try;
            r_k         <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base     <= n_base;
        r_value    <= n_value;
        r_ctl      <= n_ctl;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.code_byte = r_out_byte;
    assign o_out.last      = r_out_last;

    a_k_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> ({1'b0, r_k} < r_ctl.total))
        else $error("byte index beyond instruction length");

    a_pad_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_ctl.enc_len <= r_ctl.total))
        else $error("encoding longer than emitted length");

    a_try_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH) |-> (r_try >= 4'd1 && r_try <= 4'(MAX_TRY)))
        else $error("search length out of range");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_emit_last) |=> (r_state == ST_IDLE && o_out.last))
        else $error("final byte did not end the instruction");

endmodule

`default_nettype wire

### hw/rtl/prfx_len_unit.sv
// Shared subtract and encoding-length unit of the prefixed instruction encoder.
// Depends on prfx_pkg.
`default_nettype none

module prfx_len_unit
    import prfx_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  wire logic [WORD_BITS-1:0] i_a,
    input  wire logic [WORD_BITS-1:0] i_b,
    output logic      [WORD_BITS-1:0] o_diff,
    output logic      [3:0]           o_len
);

    logic [DATA_BITS-1:0] w_sx;
    logic [DATA_BITS-1:0] w_mag;
    logic [2:0]           w_top;
    logic                 w_neg;

    assign o_diff = i_a - i_b;
    assign w_sx   = DATA_BITS'(signed'(o_diff));
    assign w_neg  = w_sx[DATA_BITS-1];
    // Negative values continue as the complement after the first nibble.
    assign w_mag  = w_neg ? ~w_sx : w_sx;

    always_comb begin
        w_top = 3'd0;
        for (int i = 1; i < DATA_BITS / 4; i++) begin
            if (w_mag[4*i +: 4] != 4'd0) begin
                w_top = 3'(i);
            end
        end
    end

    always_comb begin
        o_len = {1'b0, w_top} + 4'd1;
        if (w_neg && o_len < 4'd2) begin
            o_len = 4'd2;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/prfx_fmt.sv
// Byte formatter of the prefixed instruction encoder: picks byte k of an instruction.
// Depends on prfx_pkg.
`default_nettype none

module prfx_fmt
    import prfx_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  wire t_emit_ctl            i_ctl,
    input  wire logic [WORD_BITS-1:0] i_value,
    input  wire logic [2:0]           i_k,
    output logic      [7:0]           o_byte
);

    logic [DATA_BITS-1:0] w_sx;
    logic                 w_neg;
    logic [3:0]           w_pad;
    logic [2:0]           w_j;
    logic [3:0]           w_nib;
    logic [3:0]           w_code;
    logic                 w_has_pre;
    logic [1:0]           w_q;

    assign w_sx      = DATA_BITS'(signed'(i_value));
    assign w_neg     = w_sx[DATA_BITS-1];
    assign w_pad     = i_ctl.total - i_ctl.enc_len;
    // Position counted from the final byte.
    assign w_j       = 3'(i_ctl.total - 4'd1 - {1'b0, i_k});
    assign w_nib     = w_neg ? ~w_sx[{w_j, 2'b00} +: 4] : w_sx[{w_j, 2'b00} +: 4];
    assign w_code    = (w_j == 3'd1 && w_neg) ? FC_NFIX : FC_PFIX;
    assign w_has_pre = (i_ctl.idx[7:4] != 4'd0);
    assign w_q       = 2'(i_k - {2'b00, w_has_pre});

    always_comb begin
        case (i_ctl.action)
            ACT_PRIMARY: begin
                if ({1'b0, i_k} < w_pad) begin
                    o_byte = PAD_BYTE;
                end else if (w_j == 3'd0) begin
                    o_byte = {i_ctl.fc, w_sx[3:0]};
                end else begin
                    o_byte = {w_code, w_nib};
                end
            end
            ACT_SECONDARY, ACT_EXTENDED: begin
                if (w_has_pre && i_k == 3'd0) begin
                    o_byte = {FC_PFIX, i_ctl.idx[7:4]};
                end else begin
                    case (w_q)
                        2'd0:    o_byte = (i_ctl.action == ACT_SECONDARY) ?
                                          {FC_OPR, i_ctl.idx[3:0]} :
                                          {FC_LDC4, i_ctl.idx[3:0]};
                        2'd1:    o_byte = EXT_BYTE1;
                        default: o_byte = EXT_BYTE2;
                    endcase
                end
            end
            default: o_byte = PAD_BYTE;
        endcase
    end

endmodule

`default_nettype wire
